/* rtl/bsm_pkg.sv */
// bsm_pkg: shared types and codes for the bank switch mapper
// no dependencies; used by the interfaces, the mapper core and the checker

package bsm_pkg;

  localparam int unsigned ActionW   = 3;
  localparam int unsigned AddrW     = 16;
  localparam int unsigned DataW     = 8;
  localparam int unsigned PhysW     = 19;
  localparam int unsigned PrgCountW = 6;
  localparam int unsigned ChrSizeW  = 9;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 9;
  localparam int unsigned PrgRegs   = 2;
  localparam int unsigned ChrRegs   = 6;
  localparam int unsigned PrgBankW  = 6;
  localparam int unsigned ChrBankW  = 8;

  // actions
  localparam logic [ActionW-1:0] ActCpuRd    = 3'd0;
  localparam logic [ActionW-1:0] ActCpuWr    = 3'd1;
  localparam logic [ActionW-1:0] ActPpuRd    = 3'd2;
  localparam logic [ActionW-1:0] ActPpuWr    = 3'd3;
  localparam logic [ActionW-1:0] ActScanline = 3'd4;
  localparam logic [ActionW-1:0] ActIrqAck   = 3'd5;

  // cpu write regions, address bits 14:13
  localparam logic [1:0] RegionBank     = 2'd0;
  localparam logic [1:0] RegionMirror   = 2'd1;
  localparam logic [1:0] RegionIrqLatch = 2'd2;
  localparam logic [1:0] RegionIrqCtl   = 2'd3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgPrgBankCount = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgChrSizeKb    = 2'd1;

  localparam logic [PrgCountW-1:0] PrgCountReset = 6'd2;
  localparam logic [PrgCountW-1:0] PrgCountMax   = 6'd32;
  localparam logic [ChrSizeW-1:0]  ChrSizeReset  = 9'd256;

  typedef struct packed {
    logic [PrgRegs-1:0][PrgBankW-1:0] prg_bank;
    logic [ChrRegs-1:0][ChrBankW-1:0] chr_bank;
    logic                             prg_mode;
    logic                             chr_invert;
    logic [PrgCountW-1:0]             prg_count;
    logic [ChrSizeW-1:0]              chr_size;
  } bsm_map_state_t;

endpackage

/* rtl/bsm_if.sv */
// bsm_if: valid/ready channel interfaces for events, results and config writes
// depends on bsm_pkg

interface bsm_in_if import bsm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ActionW-1:0] action;
  logic [AddrW-1:0]   address;
  logic [DataW-1:0]   write_data;

  modport source (output valid, action, address, write_data, input ready);
  modport sink   (input valid, action, address, write_data, output ready);
endinterface

interface bsm_out_if import bsm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             handled;
  logic [PhysW-1:0] physical_address;
  logic             irq_line;
  logic             mirror_horizontal;

  modport source (output valid, handled, physical_address, irq_line, mirror_horizontal,
                  input ready);
  modport sink   (input valid, handled, physical_address, irq_line, mirror_horizontal,
                  output ready);
endinterface

interface bsm_cfg_if import bsm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/bsm_map.sv */
// bsm_map: combinational prg/chr address translation and range check
// depends on bsm_pkg

module bsm_map import bsm_pkg::*; (
  input  logic [ActionW-1:0] action,
  input  logic [AddrW-1:0]   address,
  input  bsm_map_state_t     st,
  output logic               hit,
  output logic [PhysW-1:0]   phys
);

  logic [PrgCountW-1:0] count;
  logic [PrgCountW:0]   bank_limit;
  logic [PrgCountW:0]   prg_bank;
  logic [1:0]           win;
  logic                 cpu_hit;
  logic [2:0]           slot;
  logic [2:0]           chr_idx;
  logic [ChrBankW-1:0]  chr_reg;
  logic [ChrBankW-1:0]  chr_kb;
  logic                 ppu_hit;

  assign count      = (st.prg_count > PrgCountMax) ? PrgCountMax : st.prg_count;
  assign bank_limit = {count, 1'b0};
  assign win        = address[14:13];

  always_comb begin
    if (win == 2'd1) begin
      prg_bank = {1'b0, st.prg_bank[1]};
    end else if (win == 2'd3) begin
      prg_bank = bank_limit - 7'd1;
    end else if ((win == 2'd0) == st.prg_mode) begin
      prg_bank = bank_limit - 7'd2;
    end else begin
      prg_bank = {1'b0, st.prg_bank[0]};
    end
  end

  assign cpu_hit = address[15] && (count != '0) && (prg_bank < bank_limit);

  // 2KB slots take the even bank plus address bit 10
  assign slot    = address[12:10] ^ {st.chr_invert, 2'b00};
  assign chr_idx = slot[2] ? (slot - 3'd2) : {2'b00, slot[1]};
  assign chr_reg = st.chr_bank[chr_idx];
  assign chr_kb  = slot[2] ? chr_reg : {chr_reg[7:1], address[10]};
  assign ppu_hit = (address[15:13] == 3'd0) && ({1'b0, chr_kb} < st.chr_size);

  always_comb begin
    hit  = 1'b0;
    phys = '0;
    case (action)
      ActCpuRd: begin
        hit  = cpu_hit;
        phys = cpu_hit ? {prg_bank[5:0], address[12:0]} : '0;
      end
      ActCpuWr: begin
        hit = address[15];
      end
      ActPpuRd: begin
        hit  = ppu_hit;
        phys = ppu_hit ? {1'b0, chr_kb, address[9:0]} : '0;
      end
      default: begin
        hit  = 1'b0;
        phys = '0;
      end
    endcase
  end

endmodule

/* rtl/bank_switch_mapper_scanline_irq.sv */
// bank_switch_mapper_scanline_irq: cartridge bank mapper with scanline irq counter
// depends on bsm_pkg, bsm_if interfaces and bsm_map
//
// usage
//   in_if:  one event per transfer (cpu read/write, ppu read/write, scanline
//           tick, irq acknowledge) with address and write byte
//   out_if: exactly one result per event: handled flag, physical prg/chr
//           offset for reads, irq line and mirroring after the event
//   cfg_if: writes prg bank count (index 0) and chr size in kb (index 1);
//           always ready, write only while no event is in flight
// timing
//   the result of an event is in the output register in the cycle after its
//   transfer; one event per cycle sustained while out_if.ready stays high,
//   set by the single output stage; in_if.ready drops only while a result
//   is held and out_if.ready is low; a stalled result holds steady until taken
// reset
//   synchronous, active low: bank registers return to their defaults,
//   mirroring vertical, irq counter and flags clear, output empty

module bank_switch_mapper_scanline_irq import bsm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  bsm_in_if.sink    in_if,
  bsm_out_if.source out_if,
  bsm_cfg_if.sink   cfg_if
);

  logic [PrgRegs-1:0][PrgBankW-1:0] prg_bank_r, prg_bank_nxt;
  logic [ChrRegs-1:0][ChrBankW-1:0] chr_bank_r, chr_bank_nxt;
  logic [2:0]           bank_sel_r, bank_sel_nxt;
  logic                 prg_mode_r, prg_mode_nxt;
  logic                 chr_invert_r, chr_invert_nxt;
  logic                 mirror_r, mirror_nxt;
  logic [7:0]           irq_count_r, irq_count_nxt;
  logic [7:0]           irq_reload_r, irq_reload_nxt;
  logic                 irq_en_r, irq_en_nxt;
  logic                 irq_pend_r, irq_pend_nxt;
  logic                 reload_req_r, reload_req_nxt;
  logic [PrgCountW-1:0] prg_count_r;
  logic [ChrSizeW-1:0]  chr_size_r;

  logic                 out_valid_r;
  logic                 out_handled_r;
  logic [PhysW-1:0]     out_phys_r;
  logic                 out_irq_r;
  logic                 out_mirror_r;

  logic                 in_xfer;
  logic                 map_hit;
  logic [PhysW-1:0]     map_phys;
  bsm_map_state_t       map_st;
  logic [1:0]           region;
  logic                 odd;
  logic [DataW-1:0]     wdata;

  assign in_if.ready  = !out_valid_r || out_if.ready;
  assign in_xfer      = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;

  assign map_st.prg_bank   = prg_bank_r;
  assign map_st.chr_bank   = chr_bank_r;
  assign map_st.prg_mode   = prg_mode_r;
  assign map_st.chr_invert = chr_invert_r;
  assign map_st.prg_count  = prg_count_r;
  assign map_st.chr_size   = chr_size_r;

  bsm_map u_map (
    .action  (in_if.action),
    .address (in_if.address),
    .st      (map_st),
    .hit     (map_hit),
    .phys    (map_phys)
  );

  assign region = in_if.address[14:13];
  assign odd    = in_if.address[0];
  assign wdata  = in_if.write_data;

  always_comb begin
    prg_bank_nxt   = prg_bank_r;
    chr_bank_nxt   = chr_bank_r;
    bank_sel_nxt   = bank_sel_r;
    prg_mode_nxt   = prg_mode_r;
    chr_invert_nxt = chr_invert_r;
    mirror_nxt     = mirror_r;
    irq_count_nxt  = irq_count_r;
    irq_reload_nxt = irq_reload_r;
    irq_en_nxt     = irq_en_r;
    irq_pend_nxt   = irq_pend_r;
    reload_req_nxt = reload_req_r;
    if (in_xfer) begin
      case (in_if.action)
        ActCpuWr: begin
          if (in_if.address[15]) begin
            case (region)
              RegionBank: begin
                if (!odd) begin
                  bank_sel_nxt   = wdata[2:0];
                  prg_mode_nxt   = wdata[6];
                  chr_invert_nxt = wdata[7];
                end else if (bank_sel_r < 3'd2) begin
                  chr_bank_nxt[bank_sel_r] = {wdata[7:1], 1'b0};
                end else if (bank_sel_r < 3'd6) begin
                  chr_bank_nxt[bank_sel_r] = wdata;
                end else begin
                  prg_bank_nxt[bank_sel_r[0]] = wdata[5:0];
                end
              end
              RegionMirror: begin
                if (!odd) begin
                  mirror_nxt = wdata[0];
                end
              end
              RegionIrqLatch: begin
                if (!odd) begin
                  irq_reload_nxt = wdata;
                end else begin
                  reload_req_nxt = 1'b1;
                end
              end
              RegionIrqCtl: begin
                if (!odd) begin
                  irq_en_nxt   = 1'b0;
                  irq_pend_nxt = 1'b0;
                end else begin
                  irq_en_nxt = 1'b1;
                end
              end
              default: begin
                mirror_nxt = mirror_r;
              end
            endcase
          end
        end
        ActScanline: begin
          if (irq_count_r == 8'd0 || reload_req_r) begin
            irq_count_nxt  = irq_reload_r;
            reload_req_nxt = 1'b0;
          end else begin
            irq_count_nxt = irq_count_r - 8'd1;
          end
          if (irq_count_nxt == 8'd0 && irq_en_r) begin
            irq_pend_nxt = 1'b1;
          end
        end
        ActIrqAck: begin
          irq_pend_nxt = 1'b0;
        end
        default: begin
          irq_pend_nxt = irq_pend_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_bank_r   <= {6'd1, 6'd0};
      chr_bank_r   <= {8'd5, 8'd4, 8'd3, 8'd2, 8'd1, 8'd0};
      bank_sel_r   <= '0;
      prg_mode_r   <= 1'b0;
      chr_invert_r <= 1'b0;
      mirror_r     <= 1'b0;
      irq_count_r  <= '0;
      irq_reload_r <= '0;
      irq_en_r     <= 1'b0;
      irq_pend_r   <= 1'b0;
      reload_req_r <= 1'b0;
      prg_count_r  <= PrgCountReset;
      chr_size_r   <= ChrSizeReset;
      out_valid_r  <= 1'b0;
    end else begin
      prg_bank_r   <= prg_bank_nxt;
      chr_bank_r   <= chr_bank_nxt;
      bank_sel_r   <= bank_sel_nxt;
      prg_mode_r   <= prg_mode_nxt;
      chr_invert_r <= chr_invert_nxt;
      mirror_r     <= mirror_nxt;
      irq_count_r  <= irq_count_nxt;
      irq_reload_r <= irq_reload_nxt;
      irq_en_r     <= irq_en_nxt;
      irq_pend_r   <= irq_pend_nxt;
      reload_req_r <= reload_req_nxt;
      if (cfg_if.valid) begin
        case (cfg_if.index)
          CfgPrgBankCount: prg_count_r <= cfg_if.data[PrgCountW-1:0];
          CfgChrSizeKb:    chr_size_r  <= cfg_if.data[ChrSizeW-1:0];
          default: begin
            prg_count_r <= prg_count_r;
          end
        endcase
      end
      if (in_xfer) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_handled_r <= map_hit;
      out_phys_r    <= map_phys;
      out_irq_r     <= irq_pend_nxt;
      out_mirror_r  <= mirror_nxt;
    end
  end

  assign out_if.valid             = out_valid_r;
  assign out_if.handled           = out_handled_r;
  assign out_if.physical_address  = out_phys_r;
  assign out_if.irq_line          = out_irq_r;
  assign out_if.mirror_horizontal = out_mirror_r;

endmodule

/* rtl/bsm_checker.sv */
// bsm_checker: port-level assertions for the bank switch mapper
// depends on bsm_pkg; bound to bank_switch_mapper_scanline_irq

module bsm_checker import bsm_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [ActionW-1:0] in_action,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_handled,
  input logic [PhysW-1:0]   out_physical_address,
  input logic               out_irq_line
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("no result one cycle after input transfer");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output stage");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_handled |-> out_physical_address == '0)
    else $error("nonzero address on unhandled result");

  a_ack_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_action == ActIrqAck |=> !out_irq_line)
    else $error("irq line still high after acknowledge");

endmodule

bind bank_switch_mapper_scanline_irq bsm_checker u_bsm_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_if.valid),
  .in_ready             (in_if.ready),
  .in_action            (in_if.action),
  .out_valid            (out_if.valid),
  .out_ready            (out_if.ready),
  .out_handled          (out_if.handled),
  .out_physical_address (out_if.physical_address),
  .out_irq_line         (out_if.irq_line)
);
